@@ hw/rtl/tspp_pkg.sv @@
// ============================================================================
// tspp_pkg: shared definitions of the trapezoidal step-period profile
// Widths, register map, per-axis field extraction and the structs that
// pass between the profile calculator and the top level.
// ============================================================================
package tspp_pkg;

  localparam int AXES_DEFAULT        = 3;
  localparam int PERIOD_BITS_DEFAULT = 16;

  localparam int NUM_FIELDS = 3;   // 16-bit axis fields in one register
  localparam int FIELD_BITS = 16;
  localparam int REG_W      = NUM_FIELDS * FIELD_BITS;
  localparam int NUM_REGS   = 7;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int ADDR_LSB   = 3;   // registers sit on 8-byte boundaries
  localparam int REG_IDX_W  = CFG_ADDR_W - ADDR_LSB;

  localparam int AXIS_W    = 2;
  localparam int STEP_W    = 16;
  localparam int OPERIOD_W = 16;
  localparam int COMPARE_W = 15;
  localparam int COUNT_W   = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TARGET   = 3'd0,
    REG_MOVE     = 3'd1,
    REG_START    = 3'd2,
    REG_MIN      = 3'd3,
    REG_RATE     = 3'd4,
    REG_PRESCALE = 3'd5,
    REG_LIMIT    = 3'd6
  } cfg_reg_e;

  // Settings of one axis, taken from the packed registers.
  typedef struct packed {
    logic [FIELD_BITS-1:0] target;
    logic [FIELD_BITS-1:0] move;
    logic [FIELD_BITS-1:0] start;
    logic [FIELD_BITS-1:0] min_period;
    logic [FIELD_BITS-1:0] rate;
    logic [FIELD_BITS-1:0] prescale;
    logic [FIELD_BITS-1:0] limit;
  } axis_cfg_t;

  typedef struct packed {
    logic                 stop;
    logic                 period_valid;
    logic [OPERIOD_W-1:0] period;
    logic [COMPARE_W-1:0] compare;
    logic [COUNT_W-1:0]   counter_reload;
  } calc_res_t;

  typedef struct packed {
    logic [COUNT_W-1:0] edge_count;
    logic [COUNT_W-1:0] accel_sum;
  } acc_state_t;

  // Field of one axis; axes beyond the packed fields read as zero.
  function automatic logic [FIELD_BITS-1:0] field_of(logic [REG_W-1:0] r,
                                                     logic [AXIS_W-1:0] a);
    logic [FIELD_BITS-1:0] f;
    f = '0;
    if (int'(a) < NUM_FIELDS) begin
      f = r[FIELD_BITS*a +: FIELD_BITS];
    end
    return f;
  endfunction

endpackage

@@ hw/rtl/tspp_if.sv @@
// ============================================================================
// tspp_in_if / tspp_out_if: pulse and result channels
// Valid/ready channels carrying one step pulse and one profile result.
// ============================================================================
interface tspp_in_if;
  import tspp_pkg::*;

  logic              valid;
  logic              ready;
  logic [AXIS_W-1:0] axis;
  logic [STEP_W-1:0] step_count;

  modport source (output valid, axis, step_count, input ready);
  modport sink   (input valid, axis, step_count, output ready);
endinterface

interface tspp_out_if;
  import tspp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [AXIS_W-1:0]    axis_out;
  logic                 stop;
  logic                 period_valid;
  logic [OPERIOD_W-1:0] period;
  logic [COMPARE_W-1:0] compare;
  logic [COUNT_W-1:0]   counter_reload;

  modport source (output valid, axis_out, stop, period_valid, period, compare,
                  counter_reload, input ready);
  modport sink   (input valid, axis_out, stop, period_valid, period, compare,
                  counter_reload, output ready);
endinterface

@@ hw/rtl/trapezoidal_step_period_profile.sv @@
// ============================================================================
// trapezoidal_step_period_profile: per-axis trapezoidal stepper timing
// Turns step pulses into timer reload periods along a start, accelerate,
// cruise, decelerate profile, with per-axis edge counting and stop.
// ============================================================================
//
//  Channel  Direction  Handshake        Contents
//  in_i     sink       valid / ready    axis, step_count
//  out_o    source     valid / ready    axis_out, stop, period_valid, period,
//                                       compare, counter_reload
//  APB      slave      psel / penable   seven 48-bit registers at 8 * index
//
// One pulse transaction is accepted per cycle while results drain. A pulse
// sits in the input register; its result is computed there and registered
// in the result register once that register can advance. The per-axis state
// is written along with it, so a pulse that follows directly on the same
// axis already sees it. Reset is asynchronous and clears the configuration
// registers, valid flags and per-axis state at once; no clearing pass is
// needed. A stalled result holds in the result register while the input
// register keeps filling; the input side stalls only when both are occupied.
// Pulses on an axis without a field yield no transaction and change nothing.
// ============================================================================
module trapezoidal_step_period_profile #(
  parameter int AXES        = tspp_pkg::AXES_DEFAULT,
  parameter int PERIOD_BITS = tspp_pkg::PERIOD_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tspp_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tspp_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tspp_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  tspp_in_if.sink                           in_i,
  tspp_out_if.source                        out_o
);
  import tspp_pkg::*;

  // Only axes that have a register field can ever be addressed.
  localparam int NAX = (AXES < NUM_FIELDS) ? AXES : NUM_FIELDS;
  localparam int SW  = (PERIOD_BITS > FIELD_BITS) ? PERIOD_BITS : FIELD_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [REG_W-1:0]     cfg_q [NUM_REGS];
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  logic [REG_W-1:0]     wdata;
  logic [REG_W-1:0]     start_new, rate_new;
  logic                 reload;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:ADDR_LSB];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign wdata   = pwdata[REG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        cfg_q[r] <= '0;
      end
    end else if (cfg_wr && (int'(reg_idx) < NUM_REGS)) begin
      cfg_q[reg_idx] <= wdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (int'(reg_idx) < NUM_REGS) begin
      prdata = CFG_DATA_W'(cfg_q[reg_idx]);
    end
  end

  // A write to the start period or rate reloads every current period as the
  // start period minus the rate, using the value written for that register.
  assign reload    = cfg_wr && ((reg_idx == REG_START) || (reg_idx == REG_RATE));
  assign start_new = (reg_idx == REG_START) ? wdata : cfg_q[REG_START];
  assign rate_new  = (reg_idx == REG_RATE) ? wdata : cfg_q[REG_RATE];

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic              s1_valid_q;
  logic [AXIS_W-1:0] s1_axis_q;
  logic [STEP_W-1:0] s1_cnt_q;
  logic              advance, in_acc, axis_ok;

  assign advance    = !out_o.valid || out_o.ready;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_acc     = in_i.valid && in_i.ready;
  assign axis_ok    = int'(s1_axis_q) < NAX;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_axis_q <= in_i.axis;
      s1_cnt_q  <= in_i.step_count;
    end
  end

  // --------------------------------------------------------------------------
  // Per-axis state and profile calculation
  // --------------------------------------------------------------------------
  logic [PERIOD_BITS-1:0] cur_q [NAX];
  acc_state_t             acc_q [NAX];
  logic [PERIOD_BITS-1:0] cur_sel, cur_nxt;
  acc_state_t             acc_sel, acc_nxt;
  axis_cfg_t              axis_cfg;
  calc_res_t              res;
  logic                   commit;

  always_comb begin
    cur_sel = '0;
    acc_sel = '0;
    for (int i = 0; i < NAX; i++) begin
      if (s1_axis_q == AXIS_W'(i)) begin
        cur_sel = cur_q[i];
        acc_sel = acc_q[i];
      end
    end
  end

  assign axis_cfg.target     = field_of(cfg_q[REG_TARGET], s1_axis_q);
  assign axis_cfg.move       = field_of(cfg_q[REG_MOVE], s1_axis_q);
  assign axis_cfg.start      = field_of(cfg_q[REG_START], s1_axis_q);
  assign axis_cfg.min_period = field_of(cfg_q[REG_MIN], s1_axis_q);
  assign axis_cfg.rate       = field_of(cfg_q[REG_RATE], s1_axis_q);
  assign axis_cfg.prescale   = field_of(cfg_q[REG_PRESCALE], s1_axis_q);
  assign axis_cfg.limit      = field_of(cfg_q[REG_LIMIT], s1_axis_q);

  tspp_calc #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_calc (
    .cfg_i        (axis_cfg),
    .step_count_i (s1_cnt_q),
    .cur_period_i (cur_sel),
    .acc_i        (acc_sel),
    .res_o        (res),
    .acc_o        (acc_nxt),
    .cur_period_o (cur_nxt)
  );

  // The pulse leaves the input register with a result only for a real axis.
  assign commit = s1_valid_q && advance && axis_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NAX; i++) begin
        cur_q[i] <= '0;
        acc_q[i] <= '0;
      end
    end else if (reload) begin
      for (int i = 0; i < NAX; i++) begin
        cur_q[i] <= PERIOD_BITS'(SW'(field_of(start_new, AXIS_W'(i)))
                                - SW'(field_of(rate_new, AXIS_W'(i))));
      end
    end else if (commit) begin
      for (int i = 0; i < NAX; i++) begin
        if (s1_axis_q == AXIS_W'(i)) begin
          cur_q[i] <= cur_nxt;
          acc_q[i] <= acc_nxt;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic              out_valid_q;
  logic [AXIS_W-1:0] out_axis_q;
  calc_res_t         out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= commit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_axis_q <= s1_axis_q;
      out_res_q  <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.axis_out       = out_axis_q;
  assign out_o.stop           = out_res_q.stop;
  assign out_o.period_valid   = out_res_q.period_valid;
  assign out_o.period         = out_res_q.period;
  assign out_o.compare        = out_res_q.compare;
  assign out_o.counter_reload = out_res_q.counter_reload;

endmodule

@@ hw/rtl/tspp_calc.sv @@
// ============================================================================
// tspp_calc: profile phase selection for one pulse
// Chooses start, acceleration, cruise or deceleration period, or flags stop,
// and computes the next per-axis state.
// ============================================================================
module tspp_calc #(
  parameter int PERIOD_BITS = tspp_pkg::PERIOD_BITS_DEFAULT
) (
  input  tspp_pkg::axis_cfg_t              cfg_i,
  input  logic [tspp_pkg::STEP_W-1:0]      step_count_i,
  input  logic [PERIOD_BITS-1:0]           cur_period_i,
  input  tspp_pkg::acc_state_t             acc_i,
  output tspp_pkg::calc_res_t              res_o,
  output tspp_pkg::acc_state_t             acc_o,
  output logic [PERIOD_BITS-1:0]           cur_period_o
);
  import tspp_pkg::*;

  // Enough headroom for current period plus twice the rate without wrap.
  localparam int CW = ((PERIOD_BITS > FIELD_BITS) ? PERIOD_BITS : FIELD_BITS) + 3;
  localparam logic [CW-1:0] PMASK = {{(CW-PERIOD_BITS){1'b0}}, {PERIOD_BITS{1'b1}}};

  logic [CW-1:0]      tgt_w, start_w, minp_w, rate_w, cur_w, tr_w;
  logic [CW-1:0]      cur_n, period_w;
  logic [STEP_W-1:0]  half_move;
  logic               first_half, accel_c, cruise_c, decel_c, stop;
  logic [COUNT_W-1:0] pre_inc, edge_inc;

  assign tgt_w   = CW'(cfg_i.target) & PMASK;
  assign start_w = CW'(cfg_i.start) & PMASK;
  assign minp_w  = CW'(cfg_i.min_period) & PMASK;
  assign rate_w  = CW'(cfg_i.rate);
  assign cur_w   = CW'(cur_period_i);
  assign tr_w    = tgt_w + rate_w;

  assign half_move  = cfg_i.move >> 1;
  assign first_half = step_count_i <= half_move;
  assign stop       = step_count_i >= cfg_i.limit;

  assign accel_c  = (tr_w < cur_w) && first_half;
  assign cruise_c = (tr_w >= cur_w) && (cur_w > tgt_w) && first_half;
  assign decel_c  = ((COUNT_W+1)'(step_count_i) + (COUNT_W+1)'(acc_i.accel_sum))
                    >= (COUNT_W+1)'(cfg_i.move);

  assign pre_inc  = COUNT_W'(cfg_i.prescale) + COUNT_W'(1);
  assign edge_inc = acc_i.edge_count + pre_inc;

  always_comb begin
    res_o            = '0;
    acc_o.edge_count = edge_inc;
    acc_o.accel_sum  = acc_i.accel_sum;
    cur_n            = cur_w;
    period_w         = '0;
    if (stop) begin
      res_o.stop       = 1'b1;
      acc_o.edge_count = '0;
      acc_o.accel_sum  = '0;
    end else begin
      if (tgt_w > start_w) begin
        period_w           = start_w;
        res_o.period_valid = 1'b1;
      end
      if (accel_c) begin
        if ((cur_w < rate_w) || ((cur_w - rate_w) <= minp_w)) begin
          cur_n = minp_w;
        end else begin
          cur_n = cur_w - rate_w;
        end
        period_w           = cur_n;
        res_o.period_valid = 1'b1;
        acc_o.accel_sum    = acc_i.accel_sum + pre_inc;
      end else if (cruise_c) begin
        period_w           = tgt_w;
        res_o.period_valid = 1'b1;
      end else if (decel_c) begin
        if ((cur_w + rate_w + rate_w) >= start_w) begin
          cur_n = start_w;
        end else begin
          cur_n = cur_w + rate_w;
        end
        period_w           = cur_n;
        res_o.period_valid = 1'b1;
      end
      if (res_o.period_valid) begin
        res_o.period         = period_w[OPERIOD_W-1:0];
        res_o.compare        = period_w[COMPARE_W:1];
        res_o.counter_reload = edge_inc;
      end
    end
  end

  assign cur_period_o = cur_n[PERIOD_BITS-1:0];

endmodule
